// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top level of the probe table.
// Depends on nothing; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, clocked on clk, off during reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, clocked on clk, off during reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/bpt_pkg.sv =====
// Types and constants of the breakpoint probe table.
// Used by the top level and the testbench; depends on nothing.
package bpt_pkg;

  localparam int SLOT_COUNT_DEF = 32;
  localparam int SLOT_FIELD_W   = 5;
  localparam logic [7:0] ARM_BYTE = 8'hCC;

  typedef enum logic [1:0] {
    CMD_REGISTER   = 2'd0,
    CMD_UNREGISTER = 2'd1,
    CMD_HIT        = 2'd2,
    CMD_STEP       = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOMATCH = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    TRAP_NONE  = 2'd0,
    TRAP_SET   = 2'd1,
    TRAP_CLEAR = 2'd2
  } trap_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] address;
    logic [7:0]  original_byte;
    logic        has_pre;
    logic        has_post;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [31:0]             target_address;
    logic                    patch_valid;
    logic [7:0]              patch_byte;
    logic                    call_pre;
    logic                    call_post;
    logic [1:0]              trap_action;
  } out_item_t;

  // one table entry as held in the slot memory
  typedef struct packed {
    logic [31:0] address;
    logic [7:0]  restore_byte;
    logic        pre_present;
    logic        post_present;
  } slot_ent_t;

  localparam int ENT_W = $bits(slot_ent_t);

endpackage

// ===== hdl/bpt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module bpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/breakpoint_probe_table_top.sv =====
// Breakpoint probe table: slot payload in bpt_ram, valid/stepping bits in flops.
// Flow: an accepted command walks the slot memory lowest slot first, one read per
// cycle, stops at the first match or the last slot, then a finish state forms the
// result in the output register. A new command is taken only when idle; start is
// taken again in the cycle out_strobe is high. The receiver cannot stall.
// Reset (rst_n, synchronous): clears valid and stepping bits; no clearing pass.
`include "assert_macros.svh"

module breakpoint_probe_table_top #(
  parameter int SLOT_COUNT = bpt_pkg::SLOT_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bpt_pkg::in_item_t   in_data,
  output logic                out_strobe,
  output bpt_pkg::out_item_t  out_data
);
  import bpt_pkg::*;

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic                  cmp_v_r, cmp_v_nxt;
  logic [IW-1:0]         cmp_idx_r, cmp_idx_nxt;
  logic                  found_r, found_nxt;
  logic [IW-1:0]         hit_idx_r, hit_idx_nxt;
  slot_ent_t             hit_data_r, hit_data_nxt;
  in_item_t              item_r, item_nxt;
  logic [31:0]           key_r, key_nxt;
  logic [SLOT_COUNT-1:0] valid_r, valid_nxt;
  logic [SLOT_COUNT-1:0] stepping_r, stepping_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic                  ram_we, ram_re;
  logic [IW-1:0]         ram_waddr;
  slot_ent_t             ram_wdata, ram_rdata;
  logic [ENT_W-1:0]      ram_rdata_raw;
  logic                  match;
  logic [IW-1:0]         free_idx;
  logic                  table_full;

  bpt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r[IW-1:0]),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = slot_ent_t'(ram_rdata_raw);

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IW'(i);
      end
    end
  end
  assign table_full = &valid_r;

  assign ram_re = (state_r == S_SCAN) && (idx_r != CW'(SLOT_COUNT));

  always_comb begin
    match = 1'b0;
    if (cmp_v_r && valid_r[cmp_idx_r]) begin
      if (cmd_t'(item_r.cmd) == CMD_STEP) begin
        match = stepping_r[cmp_idx_r];
      end else begin
        match = (ram_rdata.address == key_r);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    cmp_v_nxt      = cmp_v_r;
    cmp_idx_nxt    = cmp_idx_r;
    found_nxt      = found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_data_nxt   = hit_data_r;
    item_nxt       = item_r;
    key_nxt        = key_r;
    valid_nxt      = valid_r;
    stepping_nxt   = stepping_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = free_idx;
    ram_wdata      = {item_r.address, item_r.original_byte, item_r.has_pre, item_r.has_post};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt  = in_data;
          key_nxt   = (cmd_t'(in_data.cmd) == CMD_HIT) ? in_data.address - 32'd1
                                                       : in_data.address;
          idx_nxt   = '0;
          cmp_v_nxt = 1'b0;
          found_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmp_v_nxt   = ram_re;
        cmp_idx_nxt = idx_r[IW-1:0];
        if (ram_re) begin
          idx_nxt = idx_r + CW'(1);
        end
        if (match) begin
          found_nxt    = 1'b1;
          hit_idx_nxt  = cmp_idx_r;
          hit_data_nxt = ram_rdata;
          state_nxt    = S_FIN;
        end else if (cmp_v_r && cmp_idx_r == IW'(SLOT_COUNT - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        out_strobe_nxt = 1'b1;
        out_data_nxt   = '0;
        state_nxt      = S_IDLE;
        unique case (cmd_t'(item_r.cmd))
          CMD_REGISTER: begin
            if (found_r) begin
              out_data_nxt.status = ST_DUP;
            end else if (table_full) begin
              out_data_nxt.status = ST_FULL;
            end else begin
              ram_we                        = 1'b1;
              valid_nxt[free_idx]           = 1'b1;
              stepping_nxt[free_idx]        = 1'b0;
              out_data_nxt.slot             = SLOT_FIELD_W'(free_idx);
              out_data_nxt.target_address   = item_r.address;
              out_data_nxt.patch_valid      = 1'b1;
              out_data_nxt.patch_byte       = ARM_BYTE;
            end
          end
          CMD_UNREGISTER: begin
            if (!found_r) begin
              out_data_nxt.status = ST_NOMATCH;
            end else begin
              valid_nxt[hit_idx_r]        = 1'b0;
              out_data_nxt.slot           = SLOT_FIELD_W'(hit_idx_r);
              out_data_nxt.target_address = hit_data_r.address;
              out_data_nxt.patch_valid    = 1'b1;
              out_data_nxt.patch_byte     = hit_data_r.restore_byte;
            end
          end
          CMD_HIT: begin
            if (!found_r) begin
              out_data_nxt.status = ST_NOMATCH;
            end else begin
              stepping_nxt[hit_idx_r]     = 1'b1;
              out_data_nxt.slot           = SLOT_FIELD_W'(hit_idx_r);
              out_data_nxt.target_address = hit_data_r.address;
              out_data_nxt.patch_valid    = 1'b1;
              out_data_nxt.patch_byte     = hit_data_r.restore_byte;
              out_data_nxt.call_pre       = hit_data_r.pre_present;
              out_data_nxt.trap_action    = TRAP_SET;
            end
          end
          CMD_STEP: begin
            if (!found_r) begin
              out_data_nxt.status = ST_NOMATCH;
            end else begin
              stepping_nxt[hit_idx_r]     = 1'b0;
              out_data_nxt.slot           = SLOT_FIELD_W'(hit_idx_r);
              out_data_nxt.target_address = hit_data_r.address;
              out_data_nxt.patch_valid    = 1'b1;
              out_data_nxt.patch_byte     = ARM_BYTE;
              out_data_nxt.call_post      = hit_data_r.post_present;
              out_data_nxt.trap_action    = TRAP_CLEAR;
            end
          end
          default: begin
            out_data_nxt.status = ST_NOMATCH;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cmp_v_r      <= 1'b0;
      found_r      <= 1'b0;
      valid_r      <= '0;
      stepping_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cmp_v_r      <= cmp_v_nxt;
      found_r      <= found_nxt;
      valid_r      <= valid_nxt;
      stepping_r   <= stepping_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_data_r <= hit_data_nxt;
    item_r     <= item_nxt;
    key_r      <= key_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  `ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `ASSERT_NEXT(a_fin_strobe, state_r == S_FIN, out_strobe && !busy)
  `ASSERT_NEXT(a_single_beat, out_strobe, !out_strobe)
  `ASSERT_IMPL(a_fail_quiet, out_strobe && out_data.status != ST_OK,
               !out_data.patch_valid && out_data.trap_action == TRAP_NONE)

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for breakpoint_probe_table_top: directed rows, then random commands
// over four pacing phases, each result checked against a fixed expectation or an in-bench model of the slot table.
// Depends on bpt_pkg (hdl/bpt_pkg.sv) and the top level of the block.
module testbench;
  import bpt_pkg::*;

  localparam int NSLOTS          = SLOT_COUNT_DEF;
  localparam int POOL_SIZE       = 48;
  localparam int ITEMS_PER_PHASE = 290;
  localparam int DRAIN_CYCLES    = NSLOTS + 8;
  localparam int WATCHDOG_LIMIT  = 4000;

  typedef struct {
    in_item_t  item;
    bit        fixed;
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_data = '0;
  logic      out_strobe;
  out_item_t out_data;

  // typed expectation travelling with the beat on the input side
  bit        beat_fixed = 1'b0;
  out_item_t beat_fixed_res = '0;

  // model copy of the slot table
  logic      tbl_valid[NSLOTS] = '{default: 1'b0};
  logic      tbl_stepping[NSLOTS] = '{default: 1'b0};
  slot_ent_t tbl_ent[NSLOTS];

  out_item_t   pending_results[$];
  out_item_t   predicted;
  dir_row_t    dir_rows[$];
  logic [31:0] addr_pool[POOL_SIZE];

  int mismatch_count = 0;
  int accepted_count = 0;
  int result_count   = 0;
  int quiet_cycles   = 0;
  int status_seen[4] = '{default: 0};

  int phase_idle_pct[4] = '{0, 60, 0, 22};
  int phase_reg_w[4]    = '{35, 55, 20, 40};
  int phase_unreg_w[4]  = '{25, 10, 40, 20};
  int phase_hit_w[4]    = '{20, 20, 20, 20};

  breakpoint_probe_table_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  always #5 clk = ~clk;

  function automatic in_item_t mk_cmd(cmd_t cmd, logic [31:0] addr, logic [7:0] orig,
                                      logic pre, logic post);
    in_item_t it;
    it.cmd           = cmd;
    it.address       = addr;
    it.original_byte = orig;
    it.has_pre       = pre;
    it.has_post      = post;
    return it;
  endfunction

  function automatic out_item_t mk_res(status_t st, int slot, logic [31:0] tgt,
                                       logic [7:0] pbyte, logic pre, logic post, trap_t trap);
    out_item_t r;
    r.status         = st;
    r.slot           = slot[SLOT_FIELD_W-1:0];
    r.target_address = tgt;
    r.patch_valid    = (st == ST_OK);
    r.patch_byte     = pbyte;
    r.call_pre       = pre;
    r.call_post      = post;
    r.trap_action    = trap;
    return r;
  endfunction

  function automatic int find_armed(logic [31:0] addr);
    for (int i = 0; i < NSLOTS; i++) begin
      if (tbl_valid[i] && tbl_ent[i].address == addr) return i;
    end
    return -1;
  endfunction

  // advance the model table by one command and return its result
  function automatic out_item_t predict_probe_outcome(in_item_t it);
    out_item_t r;
    int        idx;
    r   = '0;
    idx = -1;
    case (it.cmd)
      CMD_REGISTER: begin
        if (find_armed(it.address) >= 0) begin
          r.status = ST_DUP;
        end else begin
          for (int i = 0; i < NSLOTS; i++) begin
            if (!tbl_valid[i] && idx < 0) idx = i;
          end
          if (idx < 0) begin
            r.status = ST_FULL;
          end else begin
            tbl_ent[idx].address      = it.address;
            tbl_ent[idx].restore_byte = it.original_byte;
            tbl_ent[idx].pre_present  = it.has_pre;
            tbl_ent[idx].post_present = it.has_post;
            tbl_valid[idx]    = 1'b1;
            tbl_stepping[idx] = 1'b0;
            r = mk_res(ST_OK, idx, it.address, ARM_BYTE, 1'b0, 1'b0, TRAP_NONE);
          end
        end
      end
      CMD_UNREGISTER: begin
        idx = find_armed(it.address);
        if (idx < 0) begin
          r.status = ST_NOMATCH;
        end else begin
          tbl_valid[idx] = 1'b0;
          r = mk_res(ST_OK, idx, tbl_ent[idx].address, tbl_ent[idx].restore_byte,
                     1'b0, 1'b0, TRAP_NONE);
        end
      end
      CMD_HIT: begin
        // instruction pointer sits one past the arm byte; wraps at 2^32
        idx = find_armed(it.address - 32'd1);
        if (idx < 0) begin
          r.status = ST_NOMATCH;
        end else begin
          tbl_stepping[idx] = 1'b1;
          r = mk_res(ST_OK, idx, tbl_ent[idx].address, tbl_ent[idx].restore_byte,
                     tbl_ent[idx].pre_present, 1'b0, TRAP_SET);
        end
      end
      default: begin
        for (int i = 0; i < NSLOTS; i++) begin
          if (tbl_valid[i] && tbl_stepping[i] && idx < 0) idx = i;
        end
        if (idx < 0) begin
          r.status = ST_NOMATCH;
        end else begin
          tbl_stepping[idx] = 1'b0;
          r = mk_res(ST_OK, idx, tbl_ent[idx].address, ARM_BYTE,
                     1'b0, tbl_ent[idx].post_present, TRAP_CLEAR);
        end
      end
    endcase
    return r;
  endfunction

  // mostly addresses from a small pool so that duplicates, hits and full tables occur
  function automatic in_item_t random_command(int ph);
    in_item_t    it;
    int          pick;
    logic [31:0] addr;
    pick = $urandom_range(99);
    addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
    if ($urandom_range(99) < 12) addr = $urandom();
    if (pick < phase_reg_w[ph]) begin
      it.cmd = CMD_REGISTER;
    end else if (pick < phase_reg_w[ph] + phase_unreg_w[ph]) begin
      it.cmd = CMD_UNREGISTER;
    end else if (pick < phase_reg_w[ph] + phase_unreg_w[ph] + phase_hit_w[ph]) begin
      it.cmd = CMD_HIT;
      addr   = addr + 32'd1;
    end else begin
      it.cmd = CMD_STEP;
    end
    it.address       = addr;
    it.original_byte = 8'($urandom_range(255));
    it.has_pre       = 1'($urandom_range(1));
    it.has_post      = 1'($urandom_range(1));
    return it;
  endfunction

  task automatic drive_beat(input in_item_t item, input bit fixed, input out_item_t want,
                            input int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start          <= 1'b1;
    in_data        <= item;
    beat_fixed     <= fixed;
    beat_fixed_res <= want;
    do @(posedge clk); while (busy);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got, inout bit bad);
    if (want !== got) begin
      if (mismatch_count < 10) begin
        $display("t=%0t mismatch in %s: expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
      bad = 1'b1;
    end
  endtask

  task automatic check_result(input out_item_t want, input out_item_t got);
    bit bad;
    bad = 1'b0;
    check_field("status", 32'(want.status), 32'(got.status), bad);
    check_field("slot", 32'(want.slot), 32'(got.slot), bad);
    check_field("target_address", want.target_address, got.target_address, bad);
    check_field("patch_valid", 32'(want.patch_valid), 32'(got.patch_valid), bad);
    check_field("patch_byte", 32'(want.patch_byte), 32'(got.patch_byte), bad);
    check_field("call_pre", 32'(want.call_pre), 32'(got.call_pre), bad);
    check_field("call_post", 32'(want.call_post), 32'(got.call_post), bad);
    check_field("trap_action", 32'(want.trap_action), 32'(got.trap_action), bad);
    if (bad) mismatch_count++;
  endtask

  // check results before queuing the beat accepted at the same edge
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      result_count++;
      status_seen[out_data.status]++;
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10) $display("t=%0t result with nothing pending", $time);
        mismatch_count++;
      end else begin
        check_result(pending_results.pop_front(), out_data);
      end
    end
    if (rst_n && start && !busy) begin
      predicted = predict_probe_outcome(in_data);
      pending_results.push_back(beat_fixed ? beat_fixed_res : predicted);
      accepted_count++;
    end
    if ((rst_n && start && !busy) || (rst_n && out_strobe)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("t=%0t no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("[breakpoint_probe_table_top] ERROR");
      $finish;
    end
  end

  initial begin
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    addr_pool[2] = 32'hFFFF_FFFE;
    addr_pool[3] = 32'h0000_0001;
    for (int i = 4; i < POOL_SIZE; i++) addr_pool[i] = $urandom();

    // empty table: every lookup misses
    dir_rows.push_back('{mk_cmd(CMD_STEP, 32'h0, 8'h00, 1'b0, 1'b0), 1'b1,
                         mk_res(ST_NOMATCH, 0, 32'h0, 8'h00, 1'b0, 1'b0, TRAP_NONE)});
    dir_rows.push_back('{mk_cmd(CMD_UNREGISTER, 32'h0000_1000, 8'hFF, 1'b1, 1'b1), 1'b1,
                         mk_res(ST_NOMATCH, 0, 32'h0, 8'h00, 1'b0, 1'b0, TRAP_NONE)});
    dir_rows.push_back('{mk_cmd(CMD_HIT, 32'h0000_1001, 8'h00, 1'b0, 1'b0), 1'b1,
                         mk_res(ST_NOMATCH, 0, 32'h0, 8'h00, 1'b0, 1'b0, TRAP_NONE)});
    // arm both address extremes
    dir_rows.push_back('{mk_cmd(CMD_REGISTER, 32'h0000_0000, 8'h00, 1'b1, 1'b0), 1'b1,
                         mk_res(ST_OK, 0, 32'h0000_0000, ARM_BYTE, 1'b0, 1'b0, TRAP_NONE)});
    dir_rows.push_back('{mk_cmd(CMD_REGISTER, 32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b1), 1'b1,
                         mk_res(ST_OK, 1, 32'hFFFF_FFFF, ARM_BYTE, 1'b0, 1'b0, TRAP_NONE)});
    dir_rows.push_back('{mk_cmd(CMD_REGISTER, 32'hFFFF_FFFF, 8'h12, 1'b1, 1'b1), 1'b1,
                         mk_res(ST_DUP, 0, 32'h0, 8'h00, 1'b0, 1'b0, TRAP_NONE)});
    // hit at IP 0 wraps back to the top address
    dir_rows.push_back('{mk_cmd(CMD_HIT, 32'h0000_0000, 8'h00, 1'b0, 1'b0), 1'b1,
                         mk_res(ST_OK, 1, 32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b0, TRAP_SET)});
    dir_rows.push_back('{mk_cmd(CMD_HIT, 32'h0000_0001, 8'h00, 1'b0, 1'b0), 1'b1,
                         mk_res(ST_OK, 0, 32'h0000_0000, 8'h00, 1'b1, 1'b0, TRAP_SET)});
    // steps take the lowest stepping slot first
    dir_rows.push_back('{mk_cmd(CMD_STEP, 32'h0, 8'h00, 1'b0, 1'b0), 1'b1,
                         mk_res(ST_OK, 0, 32'h0000_0000, ARM_BYTE, 1'b0, 1'b0, TRAP_CLEAR)});
    dir_rows.push_back('{mk_cmd(CMD_STEP, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1), 1'b1,
                         mk_res(ST_OK, 1, 32'hFFFF_FFFF, ARM_BYTE, 1'b0, 1'b1, TRAP_CLEAR)});
    dir_rows.push_back('{mk_cmd(CMD_STEP, 32'h0, 8'h00, 1'b0, 1'b0), 1'b1,
                         mk_res(ST_NOMATCH, 0, 32'h0, 8'h00, 1'b0, 1'b0, TRAP_NONE)});
    dir_rows.push_back('{mk_cmd(CMD_UNREGISTER, 32'h0000_0000, 8'hAA, 1'b1, 1'b1), 1'b1,
                         mk_res(ST_OK, 0, 32'h0000_0000, 8'h00, 1'b0, 1'b0, TRAP_NONE)});
    // unregister while stepping: the pending step must not match the freed slot
    dir_rows.push_back('{mk_cmd(CMD_HIT, 32'h0000_0000, 8'h00, 1'b0, 1'b0), 1'b1,
                         mk_res(ST_OK, 1, 32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b0, TRAP_SET)});
    dir_rows.push_back('{mk_cmd(CMD_UNREGISTER, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0), 1'b1,
                         mk_res(ST_OK, 1, 32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b0, TRAP_NONE)});
    dir_rows.push_back('{mk_cmd(CMD_STEP, 32'h0, 8'h00, 1'b0, 1'b0), 1'b1,
                         mk_res(ST_NOMATCH, 0, 32'h0, 8'h00, 1'b0, 1'b0, TRAP_NONE)});
    dir_rows.push_back('{mk_cmd(CMD_HIT, 32'h0000_0000, 8'h00, 1'b0, 1'b0), 1'b1,
                         mk_res(ST_NOMATCH, 0, 32'h0, 8'h00, 1'b0, 1'b0, TRAP_NONE)});
    // freed slots are reused lowest first
    dir_rows.push_back('{mk_cmd(CMD_REGISTER, 32'hA5A5_5A5A, 8'h5A, 1'b1, 1'b1), 1'b1,
                         mk_res(ST_OK, 0, 32'hA5A5_5A5A, ARM_BYTE, 1'b0, 1'b0, TRAP_NONE)});
    dir_rows.push_back('{mk_cmd(CMD_REGISTER, 32'h5A5A_A5A5, 8'hA5, 1'b0, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_cmd(CMD_HIT, 32'hA5A5_5A5B, 8'h33, 1'b0, 1'b1), 1'b0, '0});
    dir_rows.push_back('{mk_cmd(CMD_HIT, 32'h5A5A_A5A6, 8'hC3, 1'b1, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_cmd(CMD_UNREGISTER, 32'h1234_5678, 8'h77, 1'b1, 1'b0), 1'b1,
                         mk_res(ST_NOMATCH, 0, 32'h0, 8'h00, 1'b0, 1'b0, TRAP_NONE)});
    dir_rows.push_back('{mk_cmd(CMD_STEP, 32'h0, 8'h00, 1'b0, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_cmd(CMD_STEP, 32'h0, 8'h00, 1'b0, 1'b0), 1'b0, '0});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) drive_beat(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].want, 0);

    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        drive_beat(random_command(ph), 1'b0, '0, phase_idle_pct[ph]);
      end
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands (directed, then four pacing phases), got %0d results.",
             accepted_count, result_count);
    $display("Statuses seen: %0d ok, %0d duplicate, %0d table full, %0d no match; %0d bad.",
             status_seen[ST_OK], status_seen[ST_DUP], status_seen[ST_FULL],
             status_seen[ST_NOMATCH], mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[breakpoint_probe_table_top] OK");
    end else begin
      $display("[breakpoint_probe_table_top] ERROR");
    end
    $finish;
  end

endmodule
